// File: rtl/core/sha256_pkg.sv
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned CHAIN_WORDS = 8;
    localparam int unsigned ROUNDS      = 64;

    localparam word_t INIT_CHAIN [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one block, zero-filled after the last byte, handed from front to back
    typedef struct packed {
        logic [BLOCK_WORDS-1:0][31:0] words;
        logic                         last;
    } block_job_t;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/core/sha256_if.sv
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;
    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

// File: rtl/core/sha256_front.sv
module sha256_front
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sha256_in_if.sink  in_ch,
    output logic       job_valid,
    input  logic       job_ready,
    output block_job_t job
);

    logic [BLOCK_WORDS-1:0][31:0] words_reg;
    logic [BLOCK_WORDS-1:0][31:0] words_next;
    logic [5:0] pos_reg;
    logic [5:0] pos_next;
    logic       job_valid_reg;
    logic       job_valid_next;
    block_job_t job_reg;
    block_job_t job_next;
    logic       fire;
    logic       close;
    logic [3:0] widx;
    logic [1:0] bidx;

    assign in_ch.ready = !job_valid_reg || job_ready;
    assign fire = in_ch.valid && in_ch.ready;
    assign widx = pos_reg[5:2];
    assign bidx = pos_reg[1:0];
    assign close = fire && (in_ch.end_of_message || pos_reg == 6'd63);

    always_comb
    begin
        words_next = words_reg;
        pos_next = pos_reg;
        job_valid_next = job_valid_reg && !job_ready;
        job_next = job_reg;
        if (fire)
        begin
            // clear word on first byte
            if (bidx == 2'd0)
            begin
                words_next[widx] = '0;
            end
            words_next[widx][8*(3-bidx) +: 8] = in_ch.data_byte;
            pos_next = in_ch.end_of_message ? 6'd0 : pos_reg + 6'd1;
            if (close)
            begin
                for (int k = 0; k < BLOCK_WORDS; k++)
                begin
                    job_next.words[k] = (k > widx) ? 32'd0 : words_next[k];
                end
                job_next.last = in_ch.end_of_message;
                job_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job = job_reg;

    a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_ch.end_of_message |=> pos_reg == 6'd0)
        else $error("position not cleared after last byte");
    a_hold_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_ready |=> job_valid_reg && $stable(job_reg))
        else $error("pending block lost");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_ready |-> !in_ch.ready)
        else $error("byte taken while block pending");

endmodule

// File: rtl/core/sha256_back.sv
module sha256_back
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  block_job_t  job,
    sha256_out_if.source out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    word_t  chain_reg [CHAIN_WORDS];
    word_t  v_reg [CHAIN_WORDS];
    word_t  w_reg [BLOCK_WORDS];
    logic [5:0] rnd_reg;
    logic [2:0] emit_reg;
    logic       last_reg;
    logic       out_valid_reg;
    word_t      out_word_reg;
    logic       out_last_reg;
    word_t      s0;
    word_t      s1;
    word_t      wnew;
    word_t      t1;
    word_t      t2;
    word_t      big0;
    word_t      big1;
    word_t      ch;
    word_t      maj;
    logic       out_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        big1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + ROUND_K[rnd_reg] + w_reg[0];
        big0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (job_valid) state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:   state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (out_free && emit_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg <= '0;
            emit_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CHAIN_WORDS; k++)
            begin
                chain_reg[k] <= INIT_CHAIN[k];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    rnd_reg <= '0;
                    emit_reg <= '0;
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                ST_ADD:
                begin
                    for (int k = 0; k < CHAIN_WORDS; k++)
                    begin
                        chain_reg[k] <= chain_reg[k] + v_reg[k];
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            for (int k = 0; k < CHAIN_WORDS; k++)
                            begin
                                chain_reg[k] <= INIT_CHAIN[k];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            for (int k = 0; k < BLOCK_WORDS; k++)
            begin
                w_reg[k] <= job.words[k];
            end
            for (int k = 0; k < CHAIN_WORDS; k++)
            begin
                v_reg[k] <= chain_reg[k];
            end
            last_reg <= job.last;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++)
            begin
                w_reg[k] <= w_reg[k+1];
            end
            w_reg[BLOCK_WORDS-1] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_word_reg <= chain_reg[emit_reg];
            out_last_reg <= (emit_reg == 3'd7);
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.digest_word = out_word_reg;
    assign out_ch.digest_last = out_last_reg;

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && rnd_reg == 6'd63 |=> state_reg == ST_ADD)
        else $error("round count off");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_word_reg))
        else $error("result dropped");
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result outside emit");

endmodule

// File: rtl/core/sha256_block_hash.sv
// channel | dir | payload
// in_ch   | in  | data_byte[7:0], end_of_message
// out_ch  | out | digest_word[31:0], digest_last
// one byte per cycle unless a closed block is pending and the back end is not idle
// each closed block: load, 64 rounds on one round unit, add into the chain
// last byte adds 8 digest transactions, one per cycle when out_ch is ready
// front holds one closed block; bytes stall only while it waits on a busy back end
// async reset loads the initial hash values and clears the byte position
module sha256_block_hash
    import sha256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);

    logic       job_valid;
    logic       job_ready;
    block_job_t job;

    sha256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    sha256_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_ch    (out_ch)
    );

endmodule

// File: tb/sha256_block_hash_tb.sv
module sha256_block_hash_tb;
    import sha256_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eom;
    } byte_item_t;

    typedef struct packed {
        word_t word;
        logic  last;
    } digest_item_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       eom;
        logic       has_fixed;
        word_t      fixed_first;
    } dir_row_t;

    logic clk;
    logic rst_n;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_block_hash dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    word_t        hash_chain [CHAIN_WORDS];
    word_t        msg_block [BLOCK_WORDS];
    int unsigned  msg_pos;
    digest_item_t digest_queue [$];
    byte_item_t   byte_queue [$];
    word_t        fixed_queue [$];
    int unsigned  err_count;
    int unsigned  digest_count;
    int unsigned  message_count;
    int unsigned  expect_msgs;
    longint       cycle_count = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        word_t w [ROUNDS];
        word_t v [CHAIN_WORDS];
        word_t s0;
        word_t s1;
        word_t t1;
        word_t t2;
        for (int t = 0; t < ROUNDS; t++)
        begin
            if (t < 16)
                w[t] = msg_block[t];
            else
            begin
                s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
        end
        for (int i = 0; i < CHAIN_WORDS; i++)
            v[i] = hash_chain[i];
        for (int t = 0; t < ROUNDS; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < CHAIN_WORDS; i++)
            hash_chain[i] = hash_chain[i] + v[i];
    endtask

    task automatic hash_reset();
        for (int i = 0; i < CHAIN_WORDS; i++)
            hash_chain[i] = INIT_CHAIN[i];
        for (int i = 0; i < BLOCK_WORDS; i++)
            msg_block[i] = '0;
        msg_pos = 0;
    endtask

    task automatic hash_byte(input byte_item_t it);
        int unsigned wi;
        int unsigned sh;
        wi = msg_pos / 4;
        sh = (3 - msg_pos % 4) * 8;
        if (msg_pos % 4 == 0)
            msg_block[wi] = word_t'(it.data_byte) << sh;
        else
            msg_block[wi] = msg_block[wi] | (word_t'(it.data_byte) << sh);
        msg_pos = (msg_pos + 1) % 64;
        if (msg_pos == 0)
            compress_msg_block();
        else if (it.eom)
        begin
            for (int k = wi + 1; k < BLOCK_WORDS; k++)
                msg_block[k] = '0;
            compress_msg_block();
        end
        if (it.eom)
        begin
            for (int k = 0; k < CHAIN_WORDS; k++)
                digest_queue.push_back('{hash_chain[k], k == 7});
            for (int i = 0; i < CHAIN_WORDS; i++)
                hash_chain[i] = INIT_CHAIN[i];
            msg_pos = 0;
            message_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            hash_byte('{in_ch.data_byte, in_ch.end_of_message});
    end

    always @(posedge clk)
    begin
        digest_item_t exp_item;
        word_t        fixed;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            digest_count++;
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest transaction %h", out_ch.digest_word);
                err_count++;
            end
            else
            begin
                exp_item = digest_queue.pop_front();
                if (digest_count % 8 == 1 && fixed_queue.size() > 0)
                begin
                    fixed = fixed_queue.pop_front();
                    if (fixed !== 32'h0 && out_ch.digest_word !== fixed)
                    begin
                        $error("digest_word (table) expected %h actual %h", fixed,
                            out_ch.digest_word);
                        err_count++;
                    end
                end
                if (out_ch.digest_word !== exp_item.word)
                begin
                    $error("digest_word expected %h actual %h", exp_item.word,
                        out_ch.digest_word);
                    err_count++;
                end
                if (out_ch.digest_last !== exp_item.last)
                begin
                    $error("digest_last expected %b actual %b", exp_item.last,
                        out_ch.digest_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (cycle_count % 97 < 30)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("sha256_block_hash_tb: done, errors");
            $finish;
        end
    end

    task automatic add_message(input int unsigned len, input int unsigned kind);
        byte_item_t it;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: it.data_byte = 8'h00;
                1: it.data_byte = 8'hff;
                default: it.data_byte = 8'($urandom);
            endcase
            it.eom = (i == len - 1);
            byte_queue.push_back(it);
        end
        expect_msgs++;
    endtask

    task automatic send_bytes();
        int unsigned burst;
        int unsigned gap;
        byte_item_t  it;
        while (byte_queue.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && byte_queue.size() > 0)
            begin
                it = byte_queue.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.data_byte      <= it.data_byte;
                in_ch.end_of_message <= it.eom;
                @(posedge clk);
                while (!in_ch.ready)
                    @(posedge clk);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    dir_row_t dir_rows [] = '{
        '{8'h00, 1'b1, 1'b0, 32'h0},
        '{8'hff, 1'b1, 1'b0, 32'h0},
        '{8'h80, 1'b0, 1'b0, 32'h0},
        '{8'h01, 1'b0, 1'b0, 32'h0},
        '{8'h7f, 1'b0, 1'b0, 32'h0},
        '{8'hfe, 1'b1, 1'b0, 32'h0},
        '{8'h55, 1'b0, 1'b0, 32'h0},
        '{8'haa, 1'b0, 1'b0, 32'h0},
        '{8'h0f, 1'b0, 1'b0, 32'h0},
        '{8'hf0, 1'b0, 1'b0, 32'h0},
        '{8'hc3, 1'b1, 1'b0, 32'h0}
    };

    initial
    begin
        byte_item_t it;
        err_count            = 0;
        digest_count         = 0;
        message_count        = 0;
        expect_msgs          = 0;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.end_of_message = 1'b0;
        hash_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            it.data_byte = dir_rows[i].data_byte;
            it.eom       = dir_rows[i].eom;
            byte_queue.push_back(it);
            if (dir_rows[i].eom)
            begin
                fixed_queue.push_back(dir_rows[i].has_fixed ? dir_rows[i].fixed_first
                    : 32'h0);
                expect_msgs++;
            end
        end
        add_message(64, 0);
        add_message(64, 1);
        add_message(65, 2);
        for (int m = 0; m < 2; m++)
            add_message($urandom_range(1, 20), 2);
        add_message(4, 2);
        add_message(3, 2);
        send_bytes();

        while (digest_count < 8 * expect_msgs)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (digest_queue.size() != 0)
        begin
            $error("digest transactions missing: %0d", digest_queue.size());
            err_count++;
        end
        $display("covered %0d messages, %0d digest transactions checked",
            message_count, digest_count);
        $display("zero and all-ones blocks, exact block multiples, partial blocks");
        if (err_count == 0)
            $display("sha256_block_hash_tb: done, clean");
        else
            $display("sha256_block_hash_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_if.sv
rtl/core/sha256_front.sv
rtl/core/sha256_back.sv
rtl/core/sha256_block_hash.sv
tb/sha256_block_hash_tb.sv
